### design/set_assoc_lru_cache_tags_core_defines.svh
// Assertion macros for the set-associative LRU cache tag core.
// Included by the core RTL file, the only one that carries concurrent assertions; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SALC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SALC_ASSERT(label, clk, rst, prop, msg)
`define SALC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

### design/salc_pkg.sv
// Shared constants, types and helper functions for the cache tag core.
// No dependencies; used by every module of the block except salc_ram.
`default_nettype none

package salc_pkg;

   localparam int TOTAL_LINES    = 512;
   localparam int LINE_BYTES     = 32;
   localparam int MAX_WAYS       = 16;
   localparam int ADDR_BITS      = 32;
   localparam int HIT_COUNT_BITS = 32;

   localparam int OFFSET_BITS   = $clog2(LINE_BYTES);
   localparam int LINE_IDX_BITS = $clog2(TOTAL_LINES);
   localparam int LANE_BITS     = $clog2(MAX_WAYS);
   localparam int LANE_W1       = LANE_BITS + 1;
   localparam int ROW_COUNT     = TOTAL_LINES / MAX_WAYS;
   localparam int ROW_BITS      = $clog2(ROW_COUNT);
   localparam int LNUM_BITS     = ADDR_BITS - OFFSET_BITS;
   localparam int TAG_BITS      = LNUM_BITS - LINE_IDX_BITS + LANE_BITS;
   localparam int RANK_BITS     = LANE_BITS;
   localparam int SHAMT_BITS    = $clog2(LINE_IDX_BITS + 1);
   localparam int KLOG_BITS     = 3;
   localparam int POLICY_BITS   = 2;
   localparam int MAX_KLOG      = LANE_BITS;
   localparam int KLOG_RESET    = 1;

   // register indexes
   localparam logic CSR_WAYS_LOG2 = 1'b0;
   localparam logic CSR_POLICY    = 1'b1;

   // policy codes
   localparam logic [POLICY_BITS-1:0] POLICY_WRITE_ALLOC    = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_NO_STORE_ALLOC = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_PREFETCH_ALL   = 2'd2;
   localparam logic [POLICY_BITS-1:0] POLICY_PREFETCH_MISS  = 2'd3;

   // access kind
   localparam logic MODE_STORE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [RANK_BITS-1:0] rank;
      logic [TAG_BITS-1:0]  tag;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   typedef struct packed {
      logic                 mode;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic                      demand_fill;
      logic                      prefetch_fill;
      logic [HIT_COUNT_BITS-1:0] hit_count;
   } rsp_type;

   typedef struct packed {
      logic                 hit;
      logic [LANE_BITS-1:0] lane;
   } scan_result_type;

   typedef struct packed {
      logic touch;
      logic fill;
   } update_ctl_type;

   // ways - 1 for an associativity of 2**klog
   function automatic logic [LANE_BITS-1:0] way_mask(input logic [KLOG_BITS-1:0] klog);
      logic [LANE_W1-1:0] ways;
      ways = LANE_W1'(1) << klog;
      return LANE_BITS'(ways - LANE_W1'(1));
   endfunction

   // flushed row: all invalid, rank equal to the way number within the set
   function automatic row_type clear_row(input logic [KLOG_BITS-1:0] klog);
      row_type              row;
      logic [LANE_BITS-1:0] mask;
      mask = way_mask(klog);
      for (int j = 0; j < MAX_WAYS; j++) begin
         row[j].valid = 1'b0;
         row[j].rank  = LANE_BITS'(j) & mask;
         row[j].tag   = '0;
      end
      return row;
   endfunction

endpackage

`default_nettype wire

### design/set_assoc_lru_cache_tags_core.sv
// Each lookup is a row read, way compares (n <= 2**ways_log2 ways, stopping at a hit) and a
//   row write-back; an item is one lookup, or two with a prefetch, then a load of the response
//   register, which waits while it is full. A new request is taken only after that load.
// The shared tag comparator, stepping one way per cycle, sets the per-lookup cost.
// Reset and every ways_log2 write start a clearing pass over all 32 rows (one row per cycle).
`default_nettype none

`include "set_assoc_lru_cache_tags_core_defines.svh"

module set_assoc_lru_cache_tags_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire salc_pkg::req_type                 req_payload,
   // response channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      salc_pkg::rsp_type                 rsp_payload,
   // register write channel
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic                              csr_index,
   input  wire logic [salc_pkg::KLOG_BITS-1:0]    csr_wdata
);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   salc_pkg::state_type                  state_ff, state_in;
   logic [salc_pkg::KLOG_BITS-1:0]       klog_ff, klog_in;
   logic [salc_pkg::POLICY_BITS-1:0]     policy_ff;
   logic [salc_pkg::ROW_BITS-1:0]        clr_cnt_ff;
   logic                                 phase_ff;      // 1 while on the prefetch lookup
   logic [salc_pkg::HIT_COUNT_BITS-1:0]  hits_ff;
   logic                                 rsp_valid_ff;

   // payload
   logic                                 mode_ff;
   logic [salc_pkg::LNUM_BITS-1:0]       lnum_ff;       // line number under lookup
   logic [salc_pkg::LANE_BITS-1:0]       wc_ff;         // way being compared
   logic                                 hit_ff;
   logic                                 dfill_ff;
   logic                                 pfill_ff;
   salc_pkg::rsp_type                    rsp_ff;

   // ------------------------------------------------------------------
   // Control strobes
   // ------------------------------------------------------------------
   logic rd_en;
   logic wr_en;
   logic scan_start;
   logic scan_step;
   logic load_rsp;
   logic ways_write;
   logic req_fire;

   // ------------------------------------------------------------------
   // Address split: line base = (lnum * ways) mod lines, tag = lnum / sets
   // ------------------------------------------------------------------
   logic [salc_pkg::LANE_BITS-1:0]       mask;
   logic [salc_pkg::LINE_IDX_BITS-1:0]   line_base;
   logic [salc_pkg::ROW_BITS-1:0]        set_row;
   logic [salc_pkg::LANE_BITS-1:0]       lane_base;
   logic [salc_pkg::LANE_BITS-1:0]       lane;
   logic [salc_pkg::SHAMT_BITS-1:0]      tag_shamt;
   logic [salc_pkg::LNUM_BITS-1:0]       tag_full;
   logic [salc_pkg::TAG_BITS-1:0]        cur_tag;

   assign mask      = salc_pkg::way_mask(klog_ff);
   assign line_base = lnum_ff[salc_pkg::LINE_IDX_BITS-1:0] << klog_ff;
   assign set_row   = line_base[salc_pkg::LINE_IDX_BITS-1:salc_pkg::LANE_BITS];
   assign lane_base = line_base[salc_pkg::LANE_BITS-1:0];
   assign lane      = lane_base | wc_ff;
   assign tag_shamt = salc_pkg::SHAMT_BITS'(salc_pkg::LINE_IDX_BITS) -
                      salc_pkg::SHAMT_BITS'(klog_ff);
   assign tag_full  = lnum_ff >> tag_shamt;
   assign cur_tag   = tag_full[salc_pkg::TAG_BITS-1:0];

   // ------------------------------------------------------------------
   // Tag/rank memory, shared compare unit and row rewrite
   // ------------------------------------------------------------------
   logic [$bits(salc_pkg::row_type)-1:0] rd_data;
   logic [$bits(salc_pkg::row_type)-1:0] wr_data;
   logic [salc_pkg::ROW_BITS-1:0]        wr_addr;
   salc_pkg::row_type                    row;
   salc_pkg::row_type                    row_new;
   salc_pkg::scan_result_type            scan_res;
   salc_pkg::update_ctl_type             upd_ctl;
   logic                                 scan_match;
   logic                                 may_fill;
   logic                                 want_prefetch;

   assign row = salc_pkg::row_type'(rd_data);

   salc_ram #(
      .WIDTH ($bits(salc_pkg::row_type)),
      .DEPTH (salc_pkg::ROW_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (set_row),
      .rd_data (rd_data)
   );

   salc_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .step   (scan_step),
      .first  (wc_ff == '0),
      .row    (row),
      .lane   (lane),
      .tag    (cur_tag),
      .match  (scan_match),
      .result (scan_res)
   );

   // Prefetch lookups always allocate; a store miss skips allocation under policy 1.
   assign may_fill = phase_ff ||
                     !((policy_ff == salc_pkg::POLICY_NO_STORE_ALLOC) &&
                       (mode_ff == salc_pkg::MODE_STORE));
   assign want_prefetch = (policy_ff == salc_pkg::POLICY_PREFETCH_ALL) ||
                          ((policy_ff == salc_pkg::POLICY_PREFETCH_MISS) && !scan_res.hit);

   assign upd_ctl.fill  = !scan_res.hit && may_fill;
   assign upd_ctl.touch = scan_res.hit || upd_ctl.fill;

   salc_update u_update (
      .row       (row),
      .lane_base (lane_base),
      .klog      (klog_ff),
      .sel       (scan_res),
      .ctl       (upd_ctl),
      .tag       (cur_tag),
      .row_out   (row_new)
   );

   // The clearing pass writes flushed rows; otherwise write back the updated set row.
   assign wr_addr = (state_ff == salc_pkg::ST_CLEAR) ? clr_cnt_ff : set_row;
   assign wr_data = (state_ff == salc_pkg::ST_CLEAR) ? salc_pkg::clear_row(klog_ff) : row_new;

   // ------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------
   assign req_ready   = (state_ff == salc_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign req_fire    = req_valid && req_ready;
   assign ways_write  = csr_valid && csr_ready && (csr_index == salc_pkg::CSR_WAYS_LOG2);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Saturate associativity at the largest supported way count.
   assign klog_in = (csr_wdata > salc_pkg::KLOG_BITS'(salc_pkg::MAX_KLOG)) ?
                    salc_pkg::KLOG_BITS'(salc_pkg::MAX_KLOG) : csr_wdata;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      scan_start = 1'b0;
      scan_step  = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_cnt_ff == salc_pkg::ROW_BITS'(salc_pkg::ROW_COUNT - 1)) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         salc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = salc_pkg::ST_READ;
            end
         end
         salc_pkg::ST_READ: begin
            rd_en      = 1'b1;
            scan_start = 1'b1;
            state_in   = salc_pkg::ST_SCAN;
         end
         salc_pkg::ST_SCAN: begin
            // stop at a hit or after the last way of the set
            scan_step = 1'b1;
            if (scan_match || (wc_ff == mask)) begin
               state_in = salc_pkg::ST_WRITE;
            end
         end
         salc_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            if (!phase_ff && want_prefetch) begin
               state_in = salc_pkg::ST_READ;
            end else begin
               state_in = salc_pkg::ST_DONE;
            end
         end
         salc_pkg::ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = salc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = salc_pkg::ST_CLEAR;
         end
      endcase
      // a new associativity flushes the whole array
      if (ways_write) begin
         state_in = salc_pkg::ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_CLEAR;
         klog_ff      <= salc_pkg::KLOG_BITS'(salc_pkg::KLOG_RESET);
         policy_ff    <= salc_pkg::POLICY_WRITE_ALLOC;
         clr_cnt_ff   <= '0;
         phase_ff     <= 1'b0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (ways_write) begin
            klog_ff <= klog_in;
         end else if (csr_valid && csr_ready && (csr_index == salc_pkg::CSR_POLICY)) begin
            policy_ff <= csr_wdata[salc_pkg::POLICY_BITS-1:0];
         end

         if (ways_write) begin
            clr_cnt_ff <= '0;
         end else if (state_ff == salc_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end

         if (req_fire) begin
            phase_ff <= 1'b0;
         end else if ((state_ff == salc_pkg::ST_WRITE) && !phase_ff && want_prefetch) begin
            phase_ff <= 1'b1;
         end

         // prefetches never count
         if ((state_ff == salc_pkg::ST_WRITE) && !phase_ff && scan_res.hit) begin
            hits_ff <= hits_ff + 1'b1;
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff  <= req_payload.mode;
         lnum_ff  <= req_payload.address[salc_pkg::ADDR_BITS-1:salc_pkg::OFFSET_BITS];
         pfill_ff <= 1'b0;
      end

      if (state_ff == salc_pkg::ST_READ) begin
         wc_ff <= '0;
      end else if (scan_step) begin
         wc_ff <= wc_ff + 1'b1;
      end

      if (state_ff == salc_pkg::ST_WRITE) begin
         if (!phase_ff) begin
            hit_ff   <= scan_res.hit;
            dfill_ff <= upd_ctl.fill;
            // advance to the next line; wraps at the top of the address space
            if (want_prefetch) begin
               lnum_ff <= lnum_ff + 1'b1;
            end
         end else begin
            pfill_ff <= upd_ctl.fill;
         end
      end

      if (load_rsp) begin
         rsp_ff.hit           <= hit_ff;
         rsp_ff.demand_fill   <= dfill_ff;
         rsp_ff.prefetch_fill <= pfill_ff;
         rsp_ff.hit_count     <= hits_ff;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SALC_ASSERT(a_hit_excludes_fill, clock, reset, rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.demand_fill), "response reports both hit and demand fill")
   `SALC_ASSERT_NEXT(a_hit_count_step, clock, reset, (state_ff == salc_pkg::ST_WRITE) && !phase_ff && scan_res.hit, hits_ff == ($past(hits_ff) + 1'b1), "demand hit did not advance hit count")
   `SALC_ASSERT_NEXT(a_clear_ends, clock, reset, (state_ff == salc_pkg::ST_CLEAR) && (clr_cnt_ff == salc_pkg::ROW_BITS'(salc_pkg::ROW_COUNT - 1)) && !ways_write, state_ff == salc_pkg::ST_IDLE, "clearing pass did not end after the last row")
   `SALC_ASSERT(a_scan_in_set, clock, reset, (state_ff == salc_pkg::ST_SCAN) |-> ((wc_ff & ~mask) == '0), "way counter ran past the set")

endmodule

`default_nettype wire

### design/salc_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/salc_scan.sv
// Shared tag compare unit: checks one way per cycle and tracks hit, first empty way
// and least recent way. Depends on salc_pkg.
`default_nettype none

module salc_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              step,
   input  wire logic                              first,
   input  wire salc_pkg::row_type                 row,
   input  wire logic [salc_pkg::LANE_BITS-1:0]    lane,
   input  wire logic [salc_pkg::TAG_BITS-1:0]     tag,
   output      logic                              match,
   output      salc_pkg::scan_result_type         result
);

   logic                             found_ff;
   logic                             empty_ff;
   logic [salc_pkg::LANE_BITS-1:0]   found_lane_ff;
   logic [salc_pkg::LANE_BITS-1:0]   empty_lane_ff;
   logic [salc_pkg::LANE_BITS-1:0]   victim_lane_ff;
   logic [salc_pkg::RANK_BITS-1:0]   victim_rank_ff;
   logic                             is_empty;

   assign match    = row[lane].valid && (row[lane].tag == tag);
   assign is_empty = !row[lane].valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else if (start) begin
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else if (step) begin
         if (match) begin
            found_ff <= 1'b1;
         end
         if (is_empty) begin
            empty_ff <= 1'b1;
         end
      end
   end

   // lowest empty way wins; ties on rank keep the lower way
   always_ff @(posedge clock) begin
      if (step) begin
         if (match) begin
            found_lane_ff <= lane;
         end
         if (is_empty && !empty_ff) begin
            empty_lane_ff <= lane;
         end
         if (first || (row[lane].rank < victim_rank_ff)) begin
            victim_lane_ff <= lane;
            victim_rank_ff <= row[lane].rank;
         end
      end
   end

   always_comb begin
      result.hit = found_ff;
      if (found_ff) begin
         result.lane = found_lane_ff;
      end else if (empty_ff) begin
         result.lane = empty_lane_ff;
      end else begin
         result.lane = victim_lane_ff;
      end
   end

endmodule

`default_nettype wire

### design/salc_update.sv
// Row rewrite: LRU touch of the chosen way and tag install on a fill.
// Depends on salc_pkg.
`default_nettype none

module salc_update (
   input  wire salc_pkg::row_type               row,
   input  wire logic [salc_pkg::LANE_BITS-1:0]  lane_base,
   input  wire logic [salc_pkg::KLOG_BITS-1:0]  klog,
   input  wire salc_pkg::scan_result_type       sel,
   input  wire salc_pkg::update_ctl_type        ctl,
   input  wire logic [salc_pkg::TAG_BITS-1:0]   tag,
   output      salc_pkg::row_type               row_out
);

   logic [salc_pkg::LANE_BITS-1:0] mask;
   logic [salc_pkg::RANK_BITS-1:0] sel_rank;

   always_comb begin
      mask     = salc_pkg::way_mask(klog);
      sel_rank = row[sel.lane].rank;
      row_out  = row;
      if (ctl.touch) begin
         // age every way of the set that was more recent than the chosen one
         for (int j = 0; j < salc_pkg::MAX_WAYS; j++) begin
            if (((salc_pkg::LANE_BITS'(j) & ~mask) == lane_base) &&
                (row[j].rank > sel_rank)) begin
               row_out[j].rank = row[j].rank - 1'b1;
            end
         end
         row_out[sel.lane].rank = mask;
      end
      if (ctl.fill) begin
         row_out[sel.lane].valid = 1'b1;
         row_out[sel.lane].tag   = tag;
      end
   end

endmodule

`default_nettype wire
